// ===== hw/rtl/rtks_pkg.sv =====
`default_nettype none

package rtks_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_K_DEF       = 256;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed field widths
    localparam int KEEP_W = 9;
    localparam int SUM_W  = 40;

    // Register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_KEEP_LARGEST = 1'b1;

    // Per-beat control broadcast to every cell of the chain
    typedef struct packed {
        logic load;        // a sample beat is taken this cycle
        logic start;       // drop all kept values before this sample
        logic append;      // store grows by one
        logic shift_left;  // replace the minimum (keep-largest mode)
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/running_top_k_sum.sv =====
`default_nettype none

// Channel   | valid   | stall    | payload
// ----------+---------+----------+-----------------------------
// sample in | i_valid | o_stall  | i_sample, i_start_new
// sum out   | o_valid | i_stall  | o_running_sum
// config    | APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One sample beat per cycle while o_stall is low; once k values are kept, its sum is
// registered in the output buffer for o_valid. The MAX_K cells compare the sample
// to all kept values and shift the sorted row in parallel, setting that rate.
// Synchronous reset clears occupancy, count and sum; keep_count and
// keep_largest return to 1. No clearing pass is needed.
// A two-entry output buffer absorbs stalls; o_stall rises only when both hold a beat.
module running_top_k_sum #(
    parameter int MAX_K       = rtks_pkg::MAX_K_DEF,
    parameter int SAMPLE_BITS = rtks_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // sample channel
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  wire                                   i_start_new,
    // sum channel
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic signed [rtks_pkg::SUM_W-1:0]     o_running_sum,
    // register port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire logic [rtks_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [rtks_pkg::DATA_W-1:0]      pwdata,
    output logic [rtks_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    localparam int SUM_W  = rtks_pkg::SUM_W;
    localparam int KEEP_W = rtks_pkg::KEEP_W;
    localparam int DATA_W = rtks_pkg::DATA_W;
    localparam int CW     = $clog2(MAX_K + 1);
    localparam int EW     = (CW > KEEP_W) ? CW : KEEP_W;

    // Register file
    logic [KEEP_W-1:0]                r_keep_count;
    logic                             r_keep_largest;
    logic                             cfg_wr;
    logic [rtks_pkg::REG_IDX_W-1:0]   cfg_idx;

    // Block state
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic signed [SUM_W-1:0]          r_sum;
    logic signed [SUM_W-1:0]          n_sum;
    logic signed [SAMPLE_BITS-1:0]    r_top;
    logic signed [SAMPLE_BITS-1:0]    n_top;

    logic                             in_accept;
    logic [CW-1:0]                    cnt_eff;
    logic signed [SUM_W-1:0]          sum_eff;
    logic [EW-1:0]                    kc_ext;
    logic [CW-1:0]                    k_eff;
    logic                             append;
    logic                             hit;
    logic                             has_result;
    logic signed [SAMPLE_BITS-1:0]    old_val;
    logic signed [SUM_W-1:0]          s_ext;
    logic signed [SUM_W-1:0]          old_ext;
    rtks_pkg::t_cell_ctl              ctl;

    // Chain wiring
    logic signed [SAMPLE_BITS-1:0]    cell_val   [MAX_K];
    logic signed [SAMPLE_BITS-1:0]    cell_term  [MAX_K];
    logic                             cell_gt    [MAX_K];
    logic                             cell_lt    [MAX_K];
    logic                             cell_valid [MAX_K];
    logic                             cell_nv    [MAX_K];

    logic                             buf_full;

    // Register writes and reads
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[rtks_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count   <= KEEP_W'(1);
            r_keep_largest <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rtks_pkg::REG_KEEP_COUNT:   r_keep_count   <= pwdata[KEEP_W-1:0];
                rtks_pkg::REG_KEEP_LARGEST: r_keep_largest <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rtks_pkg::REG_KEEP_COUNT:   prdata = DATA_W'(r_keep_count);
            rtks_pkg::REG_KEEP_LARGEST: prdata = DATA_W'(r_keep_largest);
            default:                    prdata = '0;
        endcase
    end

    // Clamp k into 1..MAX_K
    assign kc_ext = EW'(r_keep_count);

    always_comb begin
        if (kc_ext == '0) begin
            k_eff = CW'(1);
        end else if (kc_ext > EW'(MAX_K)) begin
            k_eff = CW'(MAX_K);
        end else begin
            k_eff = kc_ext[CW-1:0];
        end
    end

    // Beat control
    assign in_accept = i_valid & ~o_stall;
    assign cnt_eff   = i_start_new ? '0 : r_count;
    assign sum_eff   = i_start_new ? '0 : r_sum;
    assign append    = cnt_eff < k_eff;

    assign ctl.load       = in_accept;
    assign ctl.start      = in_accept & i_start_new;
    assign ctl.append     = append;
    assign ctl.shift_left = r_keep_largest & ~append;

    // Extreme to beat: minimum sits in slot 0, maximum in the top register
    assign old_val = r_keep_largest ? cell_val[0] : r_top;
    assign hit     = r_keep_largest ? (i_sample > old_val) : (i_sample < old_val);
    assign s_ext   = SUM_W'(i_sample);
    assign old_ext = SUM_W'(old_val);

    always_comb begin
        if (append) begin
            n_sum = sum_eff + s_ext;
        end else if (hit) begin
            n_sum = sum_eff + s_ext - old_ext;
        end else begin
            n_sum = sum_eff;
        end
    end

    assign n_count    = append ? cnt_eff + CW'(1) : cnt_eff;
    assign has_result = n_count >= k_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (in_accept) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Sorted chain
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_val;
        logic                          prev_gt;
        logic                          prev_valid;
        logic signed [SAMPLE_BITS-1:0] next_val;
        logic                          next_lt;
        logic                          next_nv;

        if (g == 0) begin : g_head
            assign prev_val   = i_sample;
            assign prev_gt    = 1'b0;
            assign prev_valid = 1'b1;
        end else begin : g_link_lo
            assign prev_val   = cell_val[g-1];
            assign prev_gt    = cell_gt[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        if (g == MAX_K - 1) begin : g_tail
            assign next_val = i_sample;
            assign next_lt  = 1'b0;
            assign next_nv  = 1'b0;
        end else begin : g_link_hi
            assign next_val = cell_val[g+1];
            assign next_lt  = cell_lt[g+1];
            assign next_nv  = cell_nv[g+1];
        end

        rtks_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_sample       (i_sample),
            .i_prev_val     (prev_val),
            .i_prev_gt      (prev_gt),
            .i_prev_valid   (prev_valid),
            .i_next_val     (next_val),
            .i_next_lt      (next_lt),
            .i_next_n_valid (next_nv),
            .o_val          (cell_val[g]),
            .o_gt           (cell_gt[g]),
            .o_lt           (cell_lt[g]),
            .o_valid        (cell_valid[g]),
            .o_n_valid      (cell_nv[g]),
            .o_top_term     (cell_term[g])
        );
    end

    // Collect the top occupied slot; only one cell offers a nonzero term
    always_comb begin
        n_top = '0;
        for (int i = 0; i < MAX_K; i++) begin
            n_top = n_top | cell_term[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // Result buffer
    rtks_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept & has_result),
        .i_data  (n_sum),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_running_sum),
        .o_full  (buf_full)
    );

    assign o_stall = buf_full;

endmodule

`default_nettype wire

// ===== hw/rtl/rtks_cell.sv =====
`default_nettype none

// One slot of the sorted chain. Valid slots hold kept values in ascending
// order from slot 0 upward; insertion shifts toward higher slots, removal of
// the minimum shifts toward lower slots.
module rtks_cell #(
    parameter int SAMPLE_BITS = rtks_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire rtks_pkg::t_cell_ctl           i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_prev_val,
    input  wire                                i_prev_gt,
    input  wire                                i_prev_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] i_next_val,
    input  wire                                i_next_lt,
    input  wire                                i_next_n_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_val,
    output logic                               o_gt,
    output logic                               o_lt,
    output logic                               o_valid,
    output logic                               o_n_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_top_term
);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] n_val;
    logic                          r_valid;
    logic                          n_valid;
    logic                          valid_eff;

    // Slot is empty once a start beat arrives
    assign valid_eff = r_valid & ~i_ctl.start;

    // While growing, empty slots count as above the sample so the tail fills
    assign o_gt = i_ctl.append ? (~valid_eff | (r_val > i_sample))
                               : (valid_eff & (r_val > i_sample));
    assign o_lt    = valid_eff & (r_val < i_sample);
    assign o_val   = r_val;
    assign o_valid = valid_eff;

    // Pick the next slot value: shift down, shift up, take the sample, or hold
    always_comb begin
        n_val = r_val;
        if (i_ctl.load) begin
            if (i_ctl.shift_left) begin
                if (i_next_lt) begin
                    n_val = i_next_val;
                end else if (o_lt) begin
                    n_val = i_sample;
                end
            end else if (o_gt) begin
                n_val = i_prev_gt ? i_prev_val : i_sample;
            end
        end
    end

    // Occupancy grows as a thermometer from slot 0
    assign n_valid   = i_ctl.load ? (valid_eff | (i_ctl.append & i_prev_valid)) : r_valid;
    assign o_n_valid = n_valid;

    // Offer the value if this slot is the top occupied one next cycle
    assign o_top_term = (n_valid & ~i_next_n_valid) ? n_val : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rtks_outbuf.sv =====
`default_nettype none

// Two-entry result buffer: output register plus skid register.
module rtks_outbuf (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_push,
    input  wire logic [rtks_pkg::SUM_W-1:0]    i_data,
    input  wire                                i_stall,
    output logic                               o_valid,
    output logic [rtks_pkg::SUM_W-1:0]         o_data,
    output logic                               o_full
);

    logic                          r_out_valid;
    logic [rtks_pkg::SUM_W-1:0]    r_out_data;
    logic                          r_skid_valid;
    logic [rtks_pkg::SUM_W-1:0]    r_skid_data;
    logic                          out_free;

    assign out_free = ~r_out_valid | ~i_stall;

    // Advance the skid entry first, else load the new beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/rtks_checker.sv =====
`default_nettype none

module rtks_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                o_stall,
    input wire                                o_valid,
    input wire                                i_stall,
    input wire logic [rtks_pkg::SUM_W-1:0]    o_running_sum
);

    // Held sum beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_running_sum))
        else $error("sum beat changed while stalled");

    // Back-pressure only with a full output register
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // Back-pressure lifts once the output drains
    a_stall_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall && o_valid)
        else $error("skid entry not advanced");

    // Reset empties both channels
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("buffer not empty after reset");

endmodule

bind running_top_k_sum rtks_checker u_rtks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_running_sum (o_running_sum)
);

`default_nettype wire
